// ===== hw/rtl/smmnd_pkg.sv =====
// Shared types and constants for the slope map (max neighbor difference) block.
package smmnd_pkg;

    // Payload and configuration widths
    localparam int HEIGHT_W    = 16;
    localparam int ROWS_CFG_W  = 13;
    localparam int COLS_CFG_W  = 11;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_IDX_W   = 1;

    // Default map limits and register reset values
    localparam int DEF_MAX_COLS = 1024;
    localparam int DEF_MAX_ROWS = 4096;
    localparam int ROWS_RST     = 4096;
    localparam int COLS_RST     = 1024;

    typedef logic [HEIGHT_W-1:0] t_height;

    // 3x3 window, indexed [row][col]; row 0 is the oldest line
    typedef t_height [2:0][2:0] t_grid;

    // Input word command codes
    typedef enum logic [0:0] {
        CMD_SAMPLE = 1'b0,
        CMD_DRAIN  = 1'b1
    } t_cmd;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAP_ROWS = 1'b0,
        REG_MAP_COLS = 1'b1
    } t_reg_idx;

    // One pending slope computation: which neighbors count and where the center sits
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
        logic shift;     // center in window column 2 instead of column 1
        logic run_end;
        logic map_end;
    } t_job;

endpackage

// ===== hw/rtl/smmnd_ifs.sv =====
// Valid/ready channel interfaces for height input words and slope output words.
interface smmnd_in_if import smmnd_pkg::*; ();
    logic    valid;
    logic    ready;
    logic    command;
    t_height height;

    modport source (output valid, output command, output height, input ready);
    modport sink   (input valid, input command, input height, output ready);
endinterface

interface smmnd_out_if import smmnd_pkg::*; ();
    logic    valid;
    logic    ready;
    t_height slope;
    logic    run_end;
    logic    map_end;

    modport source (output valid, output slope, output run_end, output map_end, input ready);
    modport sink   (input valid, input slope, input run_end, input map_end, output ready);
endinterface

// ===== hw/rtl/smmnd_line_buf.sv =====
// Two line stores (older and newer row) with one write port and a registered read.
module smmnd_line_buf import smmnd_pkg::*; #(
    parameter int  MAX_COLS = DEF_MAX_COLS,
    localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [COL_W-1:0] i_waddr,
    input  t_height          i_wdata_old,
    input  t_height          i_wdata_new,
    input  logic [COL_W-1:0] i_raddr,
    output t_height          o_rdata_old,
    output t_height          o_rdata_new
);

    t_height mem_old [MAX_COLS];
    t_height mem_new [MAX_COLS];
    t_height r_rd_old;
    t_height r_rd_new;
    logic    hit;

    // write-first: a read of the address being written returns the new data
    assign hit = i_we && (i_waddr == i_raddr);

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem_old[i_waddr] <= i_wdata_old;
            mem_new[i_waddr] <= i_wdata_new;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_old <= hit ? i_wdata_old : mem_old[i_raddr];
        r_rd_new <= hit ? i_wdata_new : mem_new[i_raddr];
    end

    assign o_rdata_old = r_rd_old;
    assign o_rdata_new = r_rd_new;

endmodule

// ===== hw/rtl/smmnd_ctrl.sv =====
// Raster counters, configuration, 3x3 window and job staging for the slope map.
module smmnd_ctrl import smmnd_pkg::*; #(
    parameter int  MAX_COLS = DEF_MAX_COLS,
    parameter int  MAX_ROWS = DEF_MAX_ROWS,
    localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_in_cmd,
    input  t_height               i_in_height,
    input  logic                  i_out_free,
    output logic                  o_job_vld,
    output t_job                  o_job,
    output t_grid                 o_win,
    output logic                  o_lb_we,
    output logic [COL_W-1:0]      o_lb_waddr,
    output t_height               o_lb_wdata_old,
    output t_height               o_lb_wdata_new,
    output logic [COL_W-1:0]      o_lb_raddr,
    input  t_height               i_lb_rdata_old,
    input  t_height               i_lb_rdata_new
);

    localparam int CNT_W    = $clog2(MAX_COLS + 1);
    localparam int ROW_W    = $clog2(MAX_ROWS + 1);
    localparam int RST_ROWS = (ROWS_RST > MAX_ROWS) ? MAX_ROWS : ROWS_RST;
    localparam int RST_COLS = (COLS_RST > MAX_COLS) ? MAX_COLS : COLS_RST;

    logic [COL_W-1:0] r_col, n_col;
    logic [COL_W-1:0] r_drain, n_drain;
    logic [ROW_W-1:0] r_row, n_row;
    logic [ROW_W-1:0] r_rows, n_rows;
    logic [CNT_W-1:0] r_cols, n_cols;
    logic             r_filled, n_filled;
    logic             r_job_vld, n_job_vld;
    logic             r_job2_vld, n_job2_vld;
    t_job             r_job, n_job;
    t_job             r_job2, n_job2;
    t_grid            r_win;
    t_height [1:0]    r_s_cur;   // last-row column at the drain position: [0] older, [1] newer
    t_height [1:0]    r_s_left;  // column to its left

    logic             adv;
    logic             accept;
    logic             do_sample;
    logic             do_drain;
    logic [CNT_W-1:0] c_ext;
    logic [CNT_W-1:0] d_ext;
    logic [CNT_W-1:0] last_col;
    logic [CNT_W-1:0] rd_next;
    logic             col_last;
    logic             drain_last;
    t_job             job_a;
    t_job             job_b;
    t_job             job_d;

    // saturate a register value to 1..hi
    function automatic logic [31:0] clamp_cfg(input logic [31:0] v, input int hi);
        logic [31:0] r;
        r = v;
        if (r == 32'd0) r = 32'd1;
        if (r > 32'(hi)) r = 32'(hi);
        return r;
    endfunction

    // handshake and item classification
    always_comb begin
        adv        = !r_job_vld || i_out_free;
        o_in_ready = adv && !r_job2_vld;
        accept     = i_in_valid && o_in_ready;
        c_ext      = CNT_W'(r_col);
        d_ext      = CNT_W'(r_drain);
        last_col   = r_cols - CNT_W'(1);
        col_last   = (c_ext == last_col);
        drain_last = (d_ext == last_col);
        do_sample  = accept && (i_in_cmd == CMD_SAMPLE) && !r_filled && (c_ext < r_cols);
        do_drain   = accept && (i_in_cmd == CMD_DRAIN) && r_filled && (d_ext < r_cols);
    end

    // job descriptors: center at window column 1, center at the last column, drain
    always_comb begin
        job_a.top     = 32'(r_row) >= 32'd2;
        job_a.bottom  = 1'b1;
        job_a.left    = 32'(r_col) >= 32'd2;
        job_a.right   = 1'b1;
        job_a.shift   = 1'b0;
        job_a.run_end = !col_last;
        job_a.map_end = 1'b0;

        job_b.top     = 32'(r_row) >= 32'd2;
        job_b.bottom  = 1'b1;
        job_b.left    = (r_col != '0);
        job_b.right   = 1'b0;
        job_b.shift   = 1'b1;
        job_b.run_end = 1'b1;
        job_b.map_end = 1'b0;

        job_d.top     = 32'(r_rows) >= 32'd2;
        job_d.bottom  = 1'b0;
        job_d.left    = (r_drain != '0);
        job_d.right   = (d_ext + CNT_W'(1)) < r_cols;
        job_d.shift   = 1'b0;
        job_d.run_end = 1'b1;
        job_d.map_end = drain_last;
    end

    // next state of counters, configuration and job stage
    always_comb begin
        n_col      = r_col;
        n_drain    = r_drain;
        n_row      = r_row;
        n_rows     = r_rows;
        n_cols     = r_cols;
        n_filled   = r_filled;
        n_job_vld  = r_job_vld;
        n_job2_vld = r_job2_vld;
        n_job      = r_job;
        n_job2     = r_job2;

        if (adv) begin
            if (r_job2_vld) begin
                n_job_vld  = 1'b1;
                n_job      = r_job2;
                n_job2_vld = 1'b0;
            end else begin
                n_job_vld = 1'b0;
            end
        end

        if (do_sample) begin
            if (r_row != '0) begin
                if (r_col != '0) begin
                    n_job_vld = 1'b1;
                    n_job     = job_a;
                    if (col_last) begin
                        n_job2_vld = 1'b1;
                        n_job2     = job_b;
                    end
                end else if (col_last) begin
                    n_job_vld = 1'b1;
                    n_job     = job_b;
                end
            end
            if (col_last) begin
                n_col = '0;
                n_row = r_row + ROW_W'(1);
                if (n_row >= r_rows) begin
                    n_filled = 1'b1;
                    n_drain  = '0;
                end
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end

        if (do_drain) begin
            n_job_vld = 1'b1;
            n_job     = job_d;
            if (drain_last) begin
                n_col    = '0;
                n_row    = '0;
                n_drain  = '0;
                n_filled = 1'b0;
            end else begin
                n_drain = r_drain + COL_W'(1);
            end
        end

        // register write starts a new map
        if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_MAP_ROWS: begin
                    n_rows = ROW_W'(clamp_cfg(32'(i_cfg_data[ROWS_CFG_W-1:0]), MAX_ROWS));
                end
                REG_MAP_COLS: begin
                    n_cols = CNT_W'(clamp_cfg(32'(i_cfg_data[COLS_CFG_W-1:0]), MAX_COLS));
                end
                default: ;
            endcase
            n_col    = '0;
            n_row    = '0;
            n_drain  = '0;
            n_filled = 1'b0;
        end
    end

    // line store read address: the column the next word will need
    always_comb begin
        rd_next = CNT_W'(n_drain) + CNT_W'(1);
        if (!i_rst_n) begin
            o_lb_raddr = '0;
        end else if (n_filled) begin
            o_lb_raddr = rd_next[COL_W-1:0];
        end else begin
            o_lb_raddr = n_col;
        end
    end

    // line store update: old newer row moves to older, sample goes to newer
    assign o_lb_we        = do_sample;
    assign o_lb_waddr     = r_col;
    assign o_lb_wdata_old = i_lb_rdata_new;
    assign o_lb_wdata_new = i_in_height;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_drain    <= '0;
            r_row      <= '0;
            r_rows     <= ROW_W'(RST_ROWS);
            r_cols     <= CNT_W'(RST_COLS);
            r_filled   <= 1'b0;
            r_job_vld  <= 1'b0;
            r_job2_vld <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_drain    <= n_drain;
            r_row      <= n_row;
            r_rows     <= n_rows;
            r_cols     <= n_cols;
            r_filled   <= n_filled;
            r_job_vld  <= n_job_vld;
            r_job2_vld <= n_job2_vld;
        end
    end

    // job descriptors
    always_ff @(posedge i_clk) begin
        r_job  <= n_job;
        r_job2 <= n_job2;
    end

    // window and drain column registers
    always_ff @(posedge i_clk) begin
        if (do_sample) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= i_lb_rdata_old;
            r_win[1][2] <= i_lb_rdata_new;
            r_win[2][2] <= i_in_height;
            // first column of a row, kept for the drain of the last row
            if (r_col == '0) begin
                r_s_cur[0] <= i_lb_rdata_new;
                r_s_cur[1] <= i_in_height;
            end
        end
        if (do_drain) begin
            r_win[0][0] <= r_s_left[0];
            r_win[1][0] <= r_s_left[1];
            r_win[0][1] <= r_s_cur[0];
            r_win[1][1] <= r_s_cur[1];
            r_win[0][2] <= i_lb_rdata_old;
            r_win[1][2] <= i_lb_rdata_new;
            r_s_left    <= r_s_cur;
            r_s_cur[0]  <= i_lb_rdata_old;
            r_s_cur[1]  <= i_lb_rdata_new;
        end
    end

    assign o_job_vld = r_job_vld;
    assign o_job     = r_job;
    assign o_win     = r_win;

endmodule

// ===== hw/rtl/smmnd_out.sv =====
// Largest neighbor difference over the masked 3x3 window and the output word register.
module smmnd_out import smmnd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_job_vld,
    input  t_job    i_job,
    input  t_grid   i_win,
    input  logic    i_out_ready,
    output logic    o_out_free,
    output logic    o_out_valid,
    output t_height o_slope,
    output logic    o_run_end,
    output logic    o_map_end
);

    t_grid   g;
    t_height ctr;
    t_height diff [8];
    t_height lvl1 [4];
    t_height lvl2 [2];
    t_height n_slope;
    logic    r_vld;
    t_height r_slope;
    logic    r_run_end;
    logic    r_map_end;

    // select the grid around the center, then masked absolute differences
    always_comb begin
        int  k;
        logic en;
        for (int i = 0; i < 3; i++) begin
            if (i_job.shift) begin
                g[i][0] = i_win[i][1];
                g[i][1] = i_win[i][2];
                g[i][2] = i_win[i][2];
            end else begin
                g[i] = i_win[i];
            end
        end
        ctr = g[1][1];
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                k  = i * 3 + j;
                en = (i != 0 || i_job.top) && (i != 2 || i_job.bottom) &&
                     (j != 0 || i_job.left) && (j != 2 || i_job.right);
                if (k != 4) begin
                    diff[(k < 4) ? k : k - 1] = !en ? '0 :
                        (ctr >= g[i][j]) ? (ctr - g[i][j]) : (g[i][j] - ctr);
                end
            end
        end
    end

    // max tree over the eight neighbors
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            lvl1[i] = (diff[2*i] > diff[2*i+1]) ? diff[2*i] : diff[2*i+1];
        end
        for (int i = 0; i < 2; i++) begin
            lvl2[i] = (lvl1[2*i] > lvl1[2*i+1]) ? lvl1[2*i] : lvl1[2*i+1];
        end
        n_slope = (lvl2[0] > lvl2[1]) ? lvl2[0] : lvl2[1];
    end

    // output word register
    assign o_out_free = !r_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_out_free) begin
            r_vld <= i_job_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_out_free && i_job_vld) begin
            r_slope   <= n_slope;
            r_run_end <= i_job.run_end;
            r_map_end <= i_job.map_end;
        end
    end

    assign o_out_valid = r_vld;
    assign o_slope     = r_slope;
    assign o_run_end   = r_run_end;
    assign o_map_end   = r_map_end;

endmodule

// ===== hw/rtl/slope_map_max_neighbor_diff_top.sv =====
// Slope map top level: largest absolute height difference to the 3x3 neighbors.
//
// Input channel i_pix takes one word per height sample in raster order
// (command = sample) or one drain word (command = drain). Once sample (r+1,c)
// is taken, the result for (r,c-1) follows, and at the last column also (r,c);
// the last row is then read out by one drain word per position, left to right.
// Output channel o_res gives slope, run_end (last word caused by an input
// word) and map_end (final position of the map). Map size comes from the
// map_rows / map_cols registers on the write port; a write restarts the map.
// An input word's first result passes the job register, then the output word
// register; a second result waits in a second job register behind it.
// Throughput: one input word per cycle while o_res is not stalled, set by the
// registered read of the two line stores and the single slope unit; a sample
// with two results (last column) holds i_pix.ready low while the second waits.
// When o_res is stalled one further word is taken into the window stage, then
// i_pix.ready drops until the output word is taken; nothing is dropped.
// Reset (synchronous, active low) clears the counters and sets the map to
// 4096 x 1024 (clamped to the parameters); line store contents are kept.
module slope_map_max_neighbor_diff_top import smmnd_pkg::*; #(
    parameter int  MAX_COLS = DEF_MAX_COLS,
    parameter int  MAX_ROWS = DEF_MAX_ROWS,
    localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    smmnd_in_if.sink              i_pix,
    smmnd_out_if.source           o_res
);

    logic             out_free;
    logic             job_vld;
    t_job             job;
    t_grid            win;
    logic             lb_we;
    logic [COL_W-1:0] lb_waddr;
    t_height          lb_wdata_old;
    t_height          lb_wdata_new;
    logic [COL_W-1:0] lb_raddr;
    t_height          lb_rdata_old;
    t_height          lb_rdata_new;

    // line stores
    smmnd_line_buf #(
        .MAX_COLS (MAX_COLS)
    ) u_line_buf (
        .i_clk       (i_clk),
        .i_we        (lb_we),
        .i_waddr     (lb_waddr),
        .i_wdata_old (lb_wdata_old),
        .i_wdata_new (lb_wdata_new),
        .i_raddr     (lb_raddr),
        .o_rdata_old (lb_rdata_old),
        .o_rdata_new (lb_rdata_new)
    );

    // counters, window and job staging
    smmnd_ctrl #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_pix.valid),
        .o_in_ready     (i_pix.ready),
        .i_in_cmd       (i_pix.command),
        .i_in_height    (i_pix.height),
        .i_out_free     (out_free),
        .o_job_vld      (job_vld),
        .o_job          (job),
        .o_win          (win),
        .o_lb_we        (lb_we),
        .o_lb_waddr     (lb_waddr),
        .o_lb_wdata_old (lb_wdata_old),
        .o_lb_wdata_new (lb_wdata_new),
        .o_lb_raddr     (lb_raddr),
        .i_lb_rdata_old (lb_rdata_old),
        .i_lb_rdata_new (lb_rdata_new)
    );

    // slope unit and output register
    smmnd_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_vld   (job_vld),
        .i_job       (job),
        .i_win       (win),
        .i_out_ready (o_res.ready),
        .o_out_free  (out_free),
        .o_out_valid (o_res.valid),
        .o_slope     (o_res.slope),
        .o_run_end   (o_res.run_end),
        .o_map_end   (o_res.map_end)
    );

endmodule

// ===== verif/slope_map_max_neighbor_diff_top_tb.sv =====
// Self-checking testbench for the slope map block: random raster maps against a local predictor.
`timescale 1ns / 100ps

module slope_map_max_neighbor_diff_top_tb import smmnd_pkg::*; ();

    // Cycles without any accepted word before the run is called hung
    localparam int unsigned QUIET_LIMIT = 2000;
    // Output hold-off used to back the block up into its input
    localparam int unsigned LONG_HOLD   = 100;
    // Quiet cycles after the last result before the map is reprogrammed
    localparam int unsigned DRAIN_GAP   = 4;
    // Input words taken over the whole run
    localparam int unsigned ITEM_GOAL   = 1700;

    // Predicts the slope words for each accepted input word and checks what comes out
    class slope_scoreboard;
        typedef t_height hgrid_t [3][3];
        typedef struct {
            t_height slope;
            logic    run_end;
            logic    map_end;
        } slope_word_t;

        slope_word_t    slopes_due[$];
        int unsigned    errors;
        int unsigned    words_taken;

        logic [ROWS_CFG_W-1:0] rows_cfg;
        logic [COLS_CFG_W-1:0] cols_cfg;
        t_height        line_far [DEF_MAX_COLS];
        t_height        line_near[DEF_MAX_COLS];
        hgrid_t         win;
        int unsigned    pos_row;
        int unsigned    pos_col;
        int unsigned    out_col;
        bit             map_done;

        function new();
            rows_cfg = ROWS_CFG_W'(ROWS_RST);
            cols_cfg = COLS_CFG_W'(COLS_RST);
            foreach (line_far[k]) begin
                line_far[k]  = '0;
                line_near[k] = '0;
            end
            foreach (win[i, j]) win[i][j] = '0;
            errors      = 0;
            words_taken = 0;
            restart();
        endfunction

        function void restart();
            pos_row  = 0;
            pos_col  = 0;
            out_col  = 0;
            map_done = 0;
        endfunction

        // Register values as the block uses them: zero counts as one, large values saturate
        function int unsigned rows_used();
            if (rows_cfg == 0) return 1;
            if (rows_cfg > DEF_MAX_ROWS) return DEF_MAX_ROWS;
            return rows_cfg;
        endfunction

        function int unsigned cols_used();
            if (cols_cfg == 0) return 1;
            if (cols_cfg > DEF_MAX_COLS) return DEF_MAX_COLS;
            return cols_cfg;
        endfunction

        function void write_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] value);
            if (idx == REG_MAP_ROWS) rows_cfg = value[ROWS_CFG_W-1:0];
            else                     cols_cfg = value[COLS_CFG_W-1:0];
            restart();
        endfunction

        // Largest |center - neighbor| over the in-bounds part of the window
        function t_height slope_of(hgrid_t g, bit top, bit bottom, bit left, bit right);
            t_height ctr;
            t_height best;
            t_height d;
            ctr  = g[1][1];
            best = '0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    if ((i == 0 && !top) || (i == 2 && !bottom) || (j == 0 && !left) ||
                        (j == 2 && !right) || (i == 1 && j == 1)) continue;
                    d = (ctr >= g[i][j]) ? ctr - g[i][j] : g[i][j] - ctr;
                    if (d > best) best = d;
                end
            end
            return best;
        endfunction

        function void queue_slope(t_height slope, bit run_end, bit map_end);
            slope_word_t w;
            w.slope   = slope;
            w.run_end = run_end;
            w.map_end = map_end;
            slopes_due.push_back(w);
        endfunction

        // Note one accepted input word; returns 0 when the block ignores it
        function bit take_word(t_cmd cmd, t_height h);
            int unsigned nrows;
            int unsigned ncols;
            int unsigned c;
            int unsigned d;
            bit          top;
            bit          lft;
            bit          rgt;
            bit          last_pos;
            hgrid_t      g;
            nrows = rows_used();
            ncols = cols_used();
            if (cmd == CMD_SAMPLE) begin
                c = pos_col;
                if (map_done || c >= ncols) return 0;
                // shift the window left and pull in the new column
                for (int i = 0; i < 3; i++) begin
                    win[i][0] = win[i][1];
                    win[i][1] = win[i][2];
                end
                win[0][2]    = line_far[c];
                win[1][2]    = line_near[c];
                win[2][2]    = h;
                line_far[c]  = line_near[c];
                line_near[c] = h;
                if (pos_row >= 1) begin
                    top = pos_row >= 2;
                    if (c >= 1)
                        queue_slope(slope_of(win, top, 1'b1, c >= 2, 1'b1), c != ncols - 1, 1'b0);
                    // last column: its own result, center in window column 2
                    if (c == ncols - 1) begin
                        for (int i = 0; i < 3; i++) begin
                            g[i][0] = win[i][1];
                            g[i][1] = win[i][2];
                            g[i][2] = win[i][2];
                        end
                        queue_slope(slope_of(g, top, 1'b1, c >= 1, 1'b0), 1'b1, 1'b0);
                    end
                end
                if (c == ncols - 1) begin
                    pos_col = 0;
                    pos_row++;
                    if (pos_row >= nrows) begin
                        map_done = 1;
                        out_col  = 0;
                    end
                end else begin
                    pos_col = c + 1;
                end
            end else begin
                d = out_col;
                if (!map_done || d >= ncols) return 0;
                // last row: no row below, neighbors from the two line stores
                lft = d >= 1;
                rgt = d + 1 < ncols;
                foreach (g[i, j]) g[i][j] = '0;
                g[0][1] = line_far[d];
                g[1][1] = line_near[d];
                if (lft) begin
                    g[0][0] = line_far[d-1];
                    g[1][0] = line_near[d-1];
                end
                if (rgt) begin
                    g[0][2] = line_far[d+1];
                    g[1][2] = line_near[d+1];
                end
                last_pos = d == ncols - 1;
                queue_slope(slope_of(g, nrows >= 2, 1'b0, lft, rgt), 1'b1, last_pos);
                if (last_pos) restart();
                else          out_col = d + 1;
            end
            words_taken++;
            return 1;
        endfunction

        task report(string msg);
            if (errors < 30) $display("ERROR @%0t: %s", $realtime, msg);
            errors++;
        endtask

        // Compare one accepted slope word with the oldest prediction
        task check_word(logic [HEIGHT_W-1:0] slope, logic run_end, logic map_end);
            slope_word_t w;
            if (slopes_due.size() == 0) begin
                report($sformatf("slope word %0d with none pending", slope));
                return;
            end
            w = slopes_due.pop_front();
            if (slope !== w.slope)
                report($sformatf("slope %0d, predicted %0d", slope, w.slope));
            if (run_end !== w.run_end)
                report($sformatf("run_end %b, predicted %b", run_end, w.run_end));
            if (map_end !== w.map_end)
                report($sformatf("map_end %b, predicted %b", map_end, w.map_end));
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    smmnd_in_if  pix_if();
    smmnd_out_if res_if();

    slope_scoreboard sb = new();

    // Stimulus knobs, changed per map
    int unsigned idle_pct      = 0;
    int unsigned out_stall_pct = 0;
    int unsigned noise_pct     = 0;
    int unsigned height_mode   = 0;
    int unsigned height_base   = 0;
    bit          hold_req      = 0;

    slope_map_max_neighbor_diff_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pix      (pix_if),
        .o_res      (res_if)
    );

    always #2 i_clk = ~i_clk;

    // Note accepted words on both channels
    always @(posedge i_clk) begin
        if (i_rst_n && pix_if.valid && pix_if.ready)
            void'(sb.take_word(t_cmd'(pix_if.command), pix_if.height));
        if (i_rst_n && res_if.valid && res_if.ready)
            sb.check_word(res_if.slope, res_if.run_end, res_if.map_end);
    end

    // Receiver: random stall bursts, plus one long hold-off on request
    initial begin : receiver
        int unsigned stall;
        stall        = 0;
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 0;
                res_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (stall > 0) begin
                stall--;
                res_if.ready <= 1'b0;
            end else if ($urandom_range(0, 99) < out_stall_pct) begin
                stall = $urandom_range(0, 4);
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Hang detection: no word moving on either channel for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) quiet = 0;
            else quiet++;
        end
        $display("slope_map_max_neighbor_diff_top: mismatch");
        $finish;
    end

    function automatic t_height pick_height();
        case (height_mode)
            0:       return t_height'($urandom);
            1:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            2:       return t_height'(height_base + $urandom_range(0, 15));
            default: begin
                if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                return t_height'($urandom);
            end
        endcase
    endfunction

    // Offer one word, with an optional idle burst first; valid stays high afterwards
    task automatic send_word(t_cmd cmd, t_height h);
        if ($urandom_range(0, 99) < idle_pct) begin
            pix_if.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        pix_if.valid   <= 1'b1;
        pix_if.command <= cmd;
        pix_if.height  <= h;
        do @(posedge i_clk); while (!pix_if.ready);
    endtask

    // Stop offering and wait until every predicted slope word has come out
    task automatic settle();
        pix_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.slopes_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    // Write map size registers while the block is idle
    task automatic program_map(bit wr_rows, bit wr_cols, logic [CFG_DATA_W-1:0] rows_v,
                               logic [CFG_DATA_W-1:0] cols_v);
        settle();
        if (wr_rows) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= REG_MAP_ROWS;
            cfg_data <= rows_v;
            sb.write_reg(REG_MAP_ROWS, rows_v);
            @(posedge i_clk);
        end
        if (wr_cols) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= REG_MAP_COLS;
            cfg_data <= cols_v;
            sb.write_reg(REG_MAP_COLS, cols_v);
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Samples, with stray drain words mixed in while the map is still filling
    task automatic feed_samples(int unsigned count);
        for (int unsigned k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < noise_pct) send_word(CMD_DRAIN, t_height'($urandom));
            send_word(CMD_SAMPLE, pick_height());
        end
    endtask

    // Drain words, with stray samples mixed in while the map is full
    task automatic feed_drains(int unsigned count);
        for (int unsigned k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < noise_pct) send_word(CMD_SAMPLE, pick_height());
            send_word(CMD_DRAIN, t_height'($urandom));
        end
    endtask

    initial begin : stimulus
        int unsigned goal;
        int unsigned rows_v;
        int unsigned cols_v;
        int unsigned total;
        int unsigned wr_sel;
        bit          must_write;
        bit          tail;
        logic [CFG_DATA_W-1:0] cols_word;

        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = '0;
        cfg_data       = '0;
        pix_if.valid   = 1'b0;
        pix_if.command = 1'b0;
        pix_if.height  = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Wide 2-row map first: fills a good part of both line stores
        idle_pct      = 10;
        out_stall_pct = 10;
        program_map(1'b1, 1'b1, 13'd2, 13'd200);
        feed_samples(400);
        feed_drains(200);

        // Single position: early drain ignored, extra sample ignored, slope 0
        idle_pct      = 0;
        out_stall_pct = 0;
        program_map(1'b1, 1'b1, 13'd0, 13'd0);
        send_word(CMD_DRAIN, 16'h1234);
        send_word(CMD_SAMPLE, 16'hFFFF);
        send_word(CMD_SAMPLE, 16'h0001);
        send_word(CMD_DRAIN, 16'h0000);

        // 3x3 checkerboard of the extreme heights: full 65535 differences
        program_map(1'b1, 1'b1, 13'd3, 13'd3);
        for (int k = 0; k < 9; k++) send_word(CMD_SAMPLE, k[0] ? 16'hFFFF : 16'h0000);
        for (int k = 0; k < 3; k++) send_word(CMD_DRAIN, 16'hFFFF);

        // Single row: every result comes from a drain word, no row above
        program_map(1'b1, 1'b1, 13'd1, 13'd4);
        send_word(CMD_SAMPLE, 16'h0000);
        send_word(CMD_SAMPLE, 16'hFFFF);
        send_word(CMD_SAMPLE, 16'h0001);
        send_word(CMD_SAMPLE, 16'hFFFE);
        for (int k = 0; k < 4; k++) send_word(CMD_DRAIN, 16'h0000);

        // Saturated sizes, upper data bits on the column write; cut short by the next write
        program_map(1'b1, 1'b1, 13'h1FFF, 13'h1FFF);
        for (int k = 0; k < 3; k++) send_word(CMD_SAMPLE, pick_height());

        // Output held off for a long stretch while samples keep coming
        settle();
        goal = ITEM_GOAL;
        program_map(1'b1, 1'b1, 13'd4, 13'd30);
        hold_req = 1;
        feed_samples(120);
        feed_drains(30);

        must_write = 1;
        tail       = 0;
        while (sb.words_taken < goal) begin
            if (!tail && sb.words_taken + 250 >= goal) begin
                tail          = 1;
                idle_pct      = 0;
                out_stall_pct = 0;
            end
            if (!tail) begin
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 8;
                    default: idle_pct = 30;
                endcase
                case ($urandom_range(0, 2))
                    0:       out_stall_pct = 0;
                    1:       out_stall_pct = 10;
                    default: out_stall_pct = 30;
                endcase
            end
            noise_pct   = $urandom_range(0, 1) ? 4 : 0;
            height_mode = $urandom_range(0, 3);
            height_base = $urandom;

            // Map size: mostly small, now and then zero, one or beyond the limits
            if (must_write || $urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 15))
                    0:       rows_v = 0;
                    1:       rows_v = $urandom_range(6, 12);
                    2:       rows_v = $urandom_range(0, 1) ? 4096 : 8191;
                    default: rows_v = $urandom_range(1, 5);
                endcase
                case ($urandom_range(0, 15))
                    0:       cols_v = 0;
                    1:       cols_v = $urandom_range(9, 40);
                    2:       cols_v = $urandom_range(0, 1) ? 1024 : 2047;
                    3:       cols_v = 1;
                    default: cols_v = $urandom_range(1, 8);
                endcase
                cols_word = {2'($urandom_range(0, 3)), 11'(cols_v)};
                wr_sel    = $urandom_range(0, 3);
                program_map(wr_sel != 1, wr_sel != 0, 13'(rows_v), cols_word);
                must_write = 0;
            end

            total = sb.rows_used() * sb.cols_used();
            if (total > 400) begin
                // large map: feed a piece of it, then restart with a new write
                feed_samples($urandom_range(1, 60));
                must_write = 1;
            end else if ($urandom_range(0, 11) == 0) begin
                feed_samples($urandom_range(0, total - 1));
                must_write = 1;
            end else begin
                feed_samples(total);
                if ($urandom_range(0, 11) == 0) begin
                    feed_drains($urandom_range(0, sb.cols_used() - 1));
                    must_write = 1;
                end else begin
                    feed_drains(sb.cols_used());
                end
            end
        end

        settle();
        if (sb.errors == 0) begin
            $display("slope_map_max_neighbor_diff_top: match");
        end else begin
            $display("slope_map_max_neighbor_diff_top: mismatch");
        end
        $finish;
    end

endmodule
